>>> rtl/report_rule_to_joystick_mapper_assert.svh
// Assertion macros for the report rule to joystick mapper.
// Used by the top level; expects clk and rst_n in scope.
`ifndef REPORT_RULE_TO_JOYSTICK_MAPPER_ASSERT_SVH
`define REPORT_RULE_TO_JOYSTICK_MAPPER_ASSERT_SVH

`ifndef SYNTH
`define RTJM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtjm assertion failed");
`define RTJM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtjm assertion failed");
`else
`define RTJM_ASSERT_IMP(lbl, ante, cons)
`define RTJM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> rtl/rtjm_pkg.sv
// Package for the report rule to joystick mapper: sizes, rule field codes,
// register indexes and the flag struct. No dependencies.
`timescale 1ns / 1ps

package rtjm_pkg;

  localparam int MAX_RULES    = 8;
  localparam int REPORT_BYTES = 64;
  localparam int IDX_CMP_W    = 9;
  localparam int RULE_W       = 32;
  localparam int COUNT_W      = 4;
  localparam int PADDR_W      = 6;
  localparam int PDATA_W      = 64;

  localparam logic [7:0] KIND_FIELD = 8'hf0;
  localparam logic [7:0] KIND_LEFT  = 8'h10;
  localparam logic [7:0] KIND_RIGHT = 8'h20;
  localparam logic [7:0] KIND_FWD   = 8'h30;
  localparam logic [7:0] KIND_BACK  = 8'h40;
  localparam logic [7:0] KIND_FIRE  = 8'h50;
  localparam logic [7:0] CMP_FIELD  = 8'h0f;
  localparam logic [7:0] CMP_EQ     = 8'h01;
  localparam logic [7:0] CMP_NE     = 8'h02;
  localparam logic [7:0] CMP_LT     = 8'h03;
  localparam logic [7:0] CMP_GT     = 8'h04;

  localparam logic [2:0] REG_RULE_COUNT = 3'd0;
  localparam logic [2:0] REG_RULES_0_1  = 3'd1;
  localparam logic [2:0] REG_RULES_2_3  = 3'd2;
  localparam logic [2:0] REG_RULES_4_5  = 3'd3;
  localparam logic [2:0] REG_RULES_6_7  = 3'd4;

  typedef struct packed {
    logic fire;
    logic fwd;
    logic back;
    logic left;
    logic right;
  } flags_t;

endpackage

>>> rtl/rtjm_rule_eval.sv
// One rule: byte capture at the rule offset and the masked compare.
// Depends on rtjm_pkg.
`timescale 1ns / 1ps

module rtjm_rule_eval
  import rtjm_pkg::*;
(
  input  logic [RULE_W-1:0] rule_word,
  input  logic              rule_en,
  input  logic [7:0]        cap_cur,
  input  logic [7:0]        in_byte,
  input  logic [5:0]        in_idx,
  input  logic              in_range,
  output logic [7:0]        cap_nxt,
  output flags_t            flags
);

  logic [7:0] kop;
  logic [7:0] offset;
  logic [7:0] mask;
  logic [7:0] value;
  logic [7:0] data;
  logic       hit;

  assign kop    = rule_word[7:0];
  assign offset = rule_word[15:8];
  assign mask   = rule_word[23:16];
  assign value  = rule_word[31:24];

  assign cap_nxt = (in_range && (offset == {2'b00, in_idx})) ? in_byte : cap_cur;
  assign data    = cap_nxt & mask;

  always_comb begin
    case (kop & CMP_FIELD)
      CMP_EQ:  hit = (data == value);
      CMP_NE:  hit = (data != value);
      CMP_LT:  hit = (data < value);
      CMP_GT:  hit = (data > value);
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    flags = '0;
    if (hit && rule_en) begin
      case (kop & KIND_FIELD)
        KIND_LEFT:  flags.left  = 1'b1;
        KIND_RIGHT: flags.right = 1'b1;
        KIND_FWD:   flags.fwd   = 1'b1;
        KIND_BACK:  flags.back  = 1'b1;
        KIND_FIRE:  flags.fire  = 1'b1;
        default:    flags = '0;
      endcase
    end
  end

endmodule

>>> rtl/report_rule_to_joystick_mapper.sv
// Top level of the report rule to joystick mapper: input register, rule
// array, result register and APB register file. Depends on rtjm_pkg,
// rtjm_rule_eval and report_rule_to_joystick_mapper_assert.svh.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   in      | in_valid/in_ready   | in_report_byte, in_byte_index, in_last_byte
//   out     | out_valid/out_ready | out_fire, out_forward, out_back, out_left,
//           |                     | out_right
//   cfg     | APB write/read      | paddr, pwdata, prdata
//
// One item per cycle is taken while in_ready is high; a last-byte item's
// result passes the input register, then the result register, to out_valid.
// Non-last items never stall in the input register. A last-byte item waits
// there, holding in_ready low, only while the result register still holds
// an untaken result.
// Synchronous active-low reset clears control, rule registers and captures.
`timescale 1ns / 1ps

`include "report_rule_to_joystick_mapper_assert.svh"

module report_rule_to_joystick_mapper
  import rtjm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_report_byte,
  input  logic [5:0]         in_byte_index,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_fire,
  output logic               out_forward,
  output logic               out_back,
  output logic               out_left,
  output logic               out_right,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [COUNT_W-1:0]                rule_count_r;
  logic [MAX_RULES-1:0][RULE_W-1:0]  rule_word_r;
  logic [MAX_RULES-1:0][7:0]         cap_r;
  logic [MAX_RULES-1:0][7:0]         cap_nxt;
  flags_t [MAX_RULES-1:0]            rule_flags;
  flags_t                            any_flags;
  logic [MAX_RULES-1:0]              rule_en;
  logic [COUNT_W-1:0]                active_cnt;
  logic                              in_range;
  logic [2:0]                        reg_idx;
  logic                              wr_en;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic [5:0] s1_idx_r;
  logic       s1_last_r;
  logic       s1_adv;

  logic       out_valid_r;
  flags_t     out_flags_r;

  // config port
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_count_r <= '0;
      rule_word_r  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RULE_COUNT: rule_count_r <= pwdata[COUNT_W-1:0];
        REG_RULES_0_1:  rule_word_r[1:0] <= pwdata;
        REG_RULES_2_3:  rule_word_r[3:2] <= pwdata;
        REG_RULES_4_5:  rule_word_r[5:4] <= pwdata;
        REG_RULES_6_7:  rule_word_r[7:6] <= pwdata;
        default:        rule_count_r <= rule_count_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RULE_COUNT: prdata = {{(PDATA_W-COUNT_W){1'b0}}, rule_count_r};
      REG_RULES_0_1:  prdata = rule_word_r[1:0];
      REG_RULES_2_3:  prdata = rule_word_r[3:2];
      REG_RULES_4_5:  prdata = rule_word_r[5:4];
      REG_RULES_6_7:  prdata = rule_word_r[7:6];
      default:        prdata = '0;
    endcase
  end

  // input register
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_report_byte;
      s1_idx_r  <= in_byte_index;
      s1_last_r <= in_last_byte;
    end
  end

  // rule array
  assign active_cnt = (rule_count_r > COUNT_W'(MAX_RULES)) ? COUNT_W'(MAX_RULES)
                                                           : rule_count_r;
  assign in_range   = ({3'b000, s1_idx_r} < IDX_CMP_W'(REPORT_BYTES));

  for (genvar g = 0; g < MAX_RULES; g++) begin : g_rule
    assign rule_en[g] = (COUNT_W'(g) < active_cnt);
    rtjm_rule_eval u_rule (
      .rule_word (rule_word_r[g]),
      .rule_en   (rule_en[g]),
      .cap_cur   (cap_r[g]),
      .in_byte   (s1_byte_r),
      .in_idx    (s1_idx_r),
      .in_range  (in_range),
      .cap_nxt   (cap_nxt[g]),
      .flags     (rule_flags[g])
    );
  end

  always_comb begin
    any_flags = '0;
    for (int i = 0; i < MAX_RULES; i++) begin
      any_flags = any_flags | rule_flags[i];
    end
  end

  // clear captures once the report is checked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '0;
    end else if (s1_adv) begin
      cap_r <= s1_last_r ? '0 : cap_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_flags_r.fire  <= any_flags.fire;
      out_flags_r.fwd   <= any_flags.fwd;
      out_flags_r.back  <= any_flags.back && !any_flags.fwd;
      out_flags_r.left  <= any_flags.left;
      out_flags_r.right <= any_flags.right && !any_flags.left;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_fire    = out_flags_r.fire;
  assign out_forward = out_flags_r.fwd;
  assign out_back    = out_flags_r.back;
  assign out_left    = out_flags_r.left;
  assign out_right   = out_flags_r.right;

  `RTJM_ASSERT_NXT(a_last_gives_result, s1_adv && s1_last_r, out_valid)
  `RTJM_ASSERT_NXT(a_caps_cleared, s1_adv && s1_last_r, cap_r == '0)
  `RTJM_ASSERT_IMP(a_fwd_over_back, out_valid, !(out_forward && out_back))
  `RTJM_ASSERT_IMP(a_left_over_right, out_valid, !(out_left && out_right))
  `RTJM_ASSERT_NXT(a_no_rules_no_flags, s1_adv && s1_last_r && rule_count_r == '0,
                   out_flags_r == '0)

endmodule

>>> tb/sv/rtjm_flag_checker.sv
// Checker for the report rule to joystick mapper: tracks register writes,
// predicts the flags of each report and compares the out channel.
// Depends on rtjm_pkg.
`timescale 1ns / 1ps

module rtjm_flag_checker
  import rtjm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_report_byte,
  input  logic [5:0]         in_byte_index,
  input  logic               in_last_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_fire,
  input  logic               out_forward,
  input  logic               out_back,
  input  logic               out_left,
  input  logic               out_right,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 fail_count,
  output int                 pending
);

  logic [COUNT_W-1:0] rule_count_q;
  logic [RULE_W-1:0]  rule_word [MAX_RULES];
  logic [7:0]         captured [MAX_RULES];
  flags_t             flags_due [$];

  initial fail_count = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_flag(input string name, input logic got, input logic want);
    if (got !== want)
      report_mismatch($sformatf("%s got %b want %b", name, got, want));
  endtask

  task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    logic [2:0] idx;
    int base;
    idx = addr[PADDR_W-1:3];
    if (idx == REG_RULE_COUNT) begin
      rule_count_q = data[COUNT_W-1:0];
    end else if (idx >= REG_RULES_0_1 && idx <= REG_RULES_6_7) begin
      base = 2 * int'(idx - REG_RULES_0_1);
      rule_word[base]     = data[31:0];
      rule_word[base + 1] = data[63:32];
    end
  endtask

  function automatic flags_t match_rules();
    flags_t f;
    int active;
    logic [7:0] kop, mask, val, d;
    logic hit, fire, fwd, back, left, right;
    fire = 1'b0;
    fwd = 1'b0;
    back = 1'b0;
    left = 1'b0;
    right = 1'b0;
    active = (int'(rule_count_q) > MAX_RULES) ? MAX_RULES : int'(rule_count_q);
    for (int i = 0; i < active; i++) begin
      kop  = rule_word[i][7:0];
      mask = rule_word[i][23:16];
      val  = rule_word[i][31:24];
      d    = captured[i] & mask;
      case (kop & CMP_FIELD)
        CMP_EQ:  hit = (d == val);
        CMP_NE:  hit = (d != val);
        CMP_LT:  hit = (d < val);
        CMP_GT:  hit = (d > val);
        default: hit = 1'b0;
      endcase
      if (hit) begin
        case (kop & KIND_FIELD)
          KIND_LEFT:  left = 1'b1;
          KIND_RIGHT: right = 1'b1;
          KIND_FWD:   fwd = 1'b1;
          KIND_BACK:  back = 1'b1;
          KIND_FIRE:  fire = 1'b1;
          default:    ;
        endcase
      end
    end
    f.fire  = fire;
    f.fwd   = fwd;
    f.back  = back && !fwd;
    f.left  = left;
    f.right = right && !left;
    return f;
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic [5:0] idx, input logic last);
    if (int'(idx) < REPORT_BYTES) begin
      for (int i = 0; i < MAX_RULES; i++)
        if (rule_word[i][15:8] == 8'(idx))
          captured[i] = b;
    end
    if (last) begin
      flags_due.push_back(match_rules());
      for (int i = 0; i < MAX_RULES; i++)
        captured[i] = '0;
    end
  endtask

  always @(posedge clk) begin
    flags_t got, want;
    if (!rst_n) begin
      rule_count_q = '0;
      for (int i = 0; i < MAX_RULES; i++) begin
        rule_word[i] = '0;
        captured[i] = '0;
      end
    end else begin
      if (psel && penable && pwrite && pready)
        write_register(paddr, pwdata);
      if (in_valid && in_ready)
        take_byte(in_report_byte, in_byte_index, in_last_byte);
      if (out_valid && out_ready) begin
        got = {out_fire, out_forward, out_back, out_left, out_right};
        if (flags_due.size() == 0) begin
          report_mismatch($sformatf("result %b with no report pending", got));
        end else begin
          want = flags_due.pop_front();
          check_flag("fire", got.fire, want.fire);
          check_flag("forward", got.fwd, want.fwd);
          check_flag("back", got.back, want.back);
          check_flag("left", got.left, want.left);
          check_flag("right", got.right, want.right);
        end
      end
    end
    pending <= flags_due.size();
  end

endmodule

>>> tb/sv/tb.sv
// Testbench top for the report rule to joystick mapper: clock, reset,
// report and register stimulus, receiver stalls and the verdict.
// Depends on rtjm_pkg, report_rule_to_joystick_mapper and rtjm_flag_checker.
`timescale 1ns / 1ps

module tb
  import rtjm_pkg::*;
();

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_report_byte = '0;
  logic [5:0]         in_byte_index = '0;
  logic               in_last_byte = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_fire, out_forward, out_back, out_left, out_right;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int fail_count;
  int pending;
  int src_idle = 0;
  int sink_stall = 0;
  int hold_len = 0;
  int hold_done = 0;
  int items_sent = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  report_rule_to_joystick_mapper dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_report_byte(in_report_byte), .in_byte_index(in_byte_index),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_fire(out_fire), .out_forward(out_forward), .out_back(out_back),
    .out_left(out_left), .out_right(out_right),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rtjm_flag_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_report_byte(in_report_byte), .in_byte_index(in_byte_index),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_fire(out_fire), .out_forward(out_forward), .out_back(out_back),
    .out_left(out_left), .out_right(out_right),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (hold_done < hold_len) begin
      out_ready <= 1'b0;
      hold_done++;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall);
    end
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [31:0] make_rule(input logic [7:0] kop, input logic [7:0] off,
                                            input logic [7:0] mask, input logic [7:0] val);
    return {val, mask, off, kop};
  endfunction

  function automatic logic [31:0] random_rule();
    logic [7:0] kinds [5];
    logic [7:0] cmps [4];
    logic [7:0] masks [5];
    logic [7:0] kind, cmp, off, mask, val;
    kinds = '{KIND_LEFT, KIND_RIGHT, KIND_FWD, KIND_BACK, KIND_FIRE};
    cmps  = '{CMP_EQ, CMP_NE, CMP_LT, CMP_GT};
    masks = '{8'hff, 8'h0f, 8'hf0, 8'h01, 8'h80};
    kind = ($urandom_range(9) == 0) ? (8'($urandom_range(15)) << 4) : kinds[$urandom_range(4)];
    cmp  = ($urandom_range(9) == 0) ? 8'($urandom_range(15)) : cmps[$urandom_range(3)];
    off  = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(7));
    mask = ($urandom_range(2) == 0) ? 8'($urandom) : masks[$urandom_range(4)];
    val  = ($urandom_range(1) == 0) ? (8'($urandom) & mask) : 8'($urandom);
    return make_rule(kind | cmp, off, mask, val);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic [5:0] ix, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_report_byte <= b;
    in_byte_index <= ix;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    items_sent++;
  endtask

  task automatic send_report();
    int len;
    logic [5:0] ix;
    if ($urandom_range(9) < 8) begin
      len = ($urandom_range(15) == 0) ? $urandom_range(9, REPORT_BYTES) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        ix = ($urandom_range(9) == 0) ? 6'($urandom) : 6'(k);
        send_item(8'($urandom), ix, k == len - 1);
      end
    end else begin
      send_item(8'($urandom), 6'($urandom), 1'($urandom));
    end
  endtask

  task automatic cfg_write(input logic [2:0] reg_idx, input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({reg_idx, 3'b000});
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
  endtask

  task automatic load_rules(input logic [COUNT_W-1:0] count, input logic [63:0] w01,
                            input logic [63:0] w23, input logic [63:0] w45,
                            input logic [63:0] w67, input bit poke_unmapped);
    cfg_write(REG_RULE_COUNT, PDATA_W'(count));
    cfg_write(REG_RULES_0_1, w01);
    cfg_write(REG_RULES_2_3, w23);
    cfg_write(REG_RULES_4_5, w45);
    cfg_write(REG_RULES_6_7, w67);
    if (poke_unmapped)
      for (int r = int'(REG_RULES_6_7) + 1; r < (1 << $bits(REG_RULES_6_7)); r++)
        cfg_write(3'(r), {$urandom, $urandom});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_setting();
    int pick;
    logic [COUNT_W-1:0] count;
    pick = $urandom_range(5);
    if (pick == 0)
      count = '0;
    else if (pick == 1)
      count = COUNT_W'($urandom_range(MAX_RULES + 1, 15));
    else
      count = COUNT_W'($urandom_range(1, MAX_RULES));
    load_rules(count, {random_rule(), random_rule()}, {random_rule(), random_rule()},
               {random_rule(), random_rule()}, {random_rule(), random_rule()},
               $urandom_range(3) == 0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    logic [31:0] r [MAX_RULES];
    int target;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    r[0] = make_rule(KIND_FWD | CMP_EQ, 8'd0, 8'hff, 8'hff);
    r[1] = make_rule(KIND_BACK | CMP_NE, 8'd63, 8'h0f, 8'h00);
    r[2] = make_rule(KIND_LEFT | CMP_LT, 8'd1, 8'hff, 8'h80);
    r[3] = make_rule(KIND_RIGHT | CMP_GT, 8'd2, 8'hf0, 8'h10);
    r[4] = make_rule(KIND_FIRE | CMP_EQ, 8'd4, 8'hff, 8'h00);
    r[5] = make_rule(KIND_FIELD | CMP_EQ, 8'd3, 8'h00, 8'h00);
    r[6] = make_rule(KIND_FIRE | CMP_FIELD, 8'd3, 8'hff, 8'h00);
    r[7] = make_rule(KIND_BACK | CMP_EQ, 8'd200, 8'hff, 8'h00);
    load_rules(COUNT_W'(MAX_RULES), {r[1], r[0]}, {r[3], r[2]}, {r[5], r[4]},
               {r[7], r[6]}, 1'b1);

    send_item(8'hff, 6'd0, 1'b1);
    send_item(8'hff, 6'd0, 1'b0);
    send_item(8'h00, 6'd1, 1'b0);
    send_item(8'hff, 6'd2, 1'b0);
    send_item(8'h00, 6'd3, 1'b0);
    send_item(8'hff, 6'd63, 1'b1);
    send_item(8'h00, 6'd0, 1'b0);
    send_item(8'hff, 6'd1, 1'b0);
    send_item(8'h00, 6'd1, 1'b0);
    send_item(8'hff, 6'd2, 1'b0);
    send_item(8'haa, 6'd63, 1'b1);
    send_item(8'h80, 6'd1, 1'b0);
    send_item(8'hff, 6'd4, 1'b0);
    send_item(8'h7f, 6'd2, 1'b1);
    settle();

    load_rules(COUNT_W'(15), {r[1], r[0]}, {r[3], r[2]}, {r[5], r[4]}, {r[7], r[6]}, 1'b0);
    send_item(8'h01, 6'd0, 1'b1);
    settle();
    load_rules('0, {r[1], r[0]}, {r[3], r[2]}, {r[5], r[4]}, {r[7], r[6]}, 1'b0);
    send_item(8'hff, 6'd0, 1'b1);
    settle();
    load_rules(COUNT_W'(1), {r[1], r[0]}, {r[3], r[2]}, {r[5], r[4]}, {r[7], r[6]}, 1'b0);
    send_item(8'hff, 6'd63, 1'b0);
    send_item(8'hff, 6'd0, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 86; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 86; end
        default: begin src_idle = 13; sink_stall = 13; end
      endcase
      for (int s = 0; s < 2; s++) begin
        settle();
        if (ph == 1 && s == 1)
          load_rules(COUNT_W'(15), '1, '1, '1, '1, 1'b0);
        else if (ph == 3 && s == 0)
          load_rules(COUNT_W'(MAX_RULES), '0, '0, '0, '0, 1'b0);
        else
          random_setting();
        if (ph == 0 && s == 0)
          hold_len += 300;
        target = items_sent + 85;
        while (items_sent < target)
          send_report();
      end
    end

    settle();
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
